// File: rtl/hds_pkg.sv
`timescale 1ns / 1ps
package hds_pkg;
   localparam int MAX_ROWS_DEF   = 128;
   localparam int MAX_COLS_DEF   = 128;
   localparam int TEMP_WIDTH_DEF = 32;

   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_RUN  = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   localparam logic [2:0] REG_ROWS = 3'd0;
   localparam logic [2:0] REG_COLS = 3'd1;
   localparam logic [2:0] REG_STEPS = 3'd2;
   localparam logic [2:0] REG_COEF_ROW = 3'd3;
   localparam logic [2:0] REG_COEF_COL = 3'd4;
endpackage

// File: rtl/hds_ram.sv
`timescale 1ns / 1ps
module hds_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/hds_alu.sv
`timescale 1ns / 1ps
// Shared multiply-accumulate: one coefficient half times one second difference per cycle with acc_en.
module hds_alu #(
   parameter int TEMP_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    clear,
   input  logic                    acc_en,
   input  logic signed [TEMP_WIDTH+2:0] diff,
   input  logic [11:0]             coef_half,
   input  logic                    high_half,
   output logic signed [TEMP_WIDTH+30:0] hi_sum,
   output logic signed [TEMP_WIDTH+30:0] lo_sum
);
   localparam int AW = TEMP_WIDTH + 31;
   logic signed [AW-1:0] prod;
   logic signed [AW-1:0] hi_ff, hi_in, lo_ff, lo_in;

   assign prod = AW'(diff) * AW'($signed({1'b0, coef_half}));

   always_comb begin
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (clear) begin
         hi_in = '0;
         lo_in = AW'(64'sd8388608);
      end else if (acc_en) begin
         if (high_half) hi_in = hi_ff + prod;
         else lo_in = lo_ff + prod;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign hi_sum = hi_ff;
   assign lo_sum = lo_ff;
endmodule

// File: rtl/heat_diffusion_stencil_2d.sv
`timescale 1ns / 1ps
// Heat diffusion engine: explicit five-point stencil over a grid held in two memory banks.
// Words on req_ carry an opcode, a row, a column and a temperature; each word gives exactly
// one rsp_ word with the read value, a status bit and the opcode echoed.
// The response word to a load or read is offered after the request has passed S_MEM and
// S_MEMW, which wait on the registered memory read; a new request is taken only after the
// response has gone. A run visits each cell in every step; an edge cell fetches only itself
// and keeps its value, while one shared multiplier forms the four partial products of each
// interior cell and one memory port fetches the cell and its four neighbors in turn.
// req_tready is low while a word is in work and while a response waits on rsp_tready;
// a stalled receiver simply holds the response. Reset clears the registers to their
// defaults and selects bank a; the grid contents are undefined until loaded.
// csr_ writes are taken at any time but are meant only while the block is idle.
module heat_diffusion_stencil_2d #(
   parameter int MAX_ROWS   = hds_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS   = hds_pkg::MAX_COLS_DEF,
   parameter int TEMP_WIDTH = hds_pkg::TEMP_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // opcode, row, col, cell_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // read_value, status, opcode_echo
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int RW = $clog2(MAX_ROWS);
   localparam int CW = $clog2(MAX_COLS);
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW = $clog2(DEPTH);
   localparam int DW = TEMP_WIDTH + 3;
   localparam int SW = TEMP_WIDTH + 31;
   localparam logic signed [TEMP_WIDTH-1:0] TMAX = {1'b0, {(TEMP_WIDTH-1){1'b1}}};
   localparam logic signed [TEMP_WIDTH-1:0] TMIN = {1'b1, {(TEMP_WIDTH-1){1'b0}}};

   typedef enum logic [3:0] {
      S_IDLE, S_MEM, S_MEMW, S_RESP, S_CELL, S_FETCH, S_FWAIT, S_MAC,
      S_WRITE, S_NEXT
   } state_type;

   logic [7:0]  rows_ff, cols_ff;
   logic [15:0] steps_ff;
   logic [23:0] cr_ff, cc_ff;
   state_type   state_ff;
   logic        bank_ff;
   logic [1:0]  op_ff;
   logic [RW-1:0] r_ff;
   logic [CW-1:0] c_ff;
   logic [15:0] s_ff;
   logic [2:0]  k_ff;
   logic [2:0]  mk_ff;
   logic signed [TEMP_WIDTH-1:0] t_ff, n_ff, s2_ff, w_ff, e_ff, val_ff;
   logic        bad_ff, edge_ff;
   logic [31:0] rd_ff;

   logic [1:0]  in_op;
   logic [6:0]  in_row, in_col;
   logic [31:0] in_val;
   logic signed [63:0] in_wide;
   logic signed [TEMP_WIDTH-1:0] in_temp;
   logic [10:0] nr, nc;
   logic        wr_a, wr_b;
   logic [AW-1:0] wr_addr, rd_addr, base;
   logic signed [TEMP_WIDTH-1:0] rd_a, rd_b, rd_cur, wr_data;
   logic signed [DW-1:0] lr, lc, mdiff;
   logic [11:0] mcoef;
   logic        mhigh, mclear, macc;
   logic signed [SW-1:0] hi_sum, lo_sum, delta;
   logic signed [SW+1:0] sum;
   logic signed [TEMP_WIDTH-1:0] newv;

   assign in_op  = req_tdata[1:0];
   assign in_row = req_tdata[8:2];
   assign in_col = req_tdata[15:9];
   assign in_val = req_tdata[47:16];
   assign in_wide = 64'($signed(in_val));
   assign in_temp = (in_wide > 64'(TMAX)) ? TMAX
                  : (in_wide < 64'(TMIN)) ? TMIN : in_wide[TEMP_WIDTH-1:0];
   assign nr = (11'(rows_ff) > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : 11'(rows_ff);
   assign nc = (11'(cols_ff) > 11'(MAX_COLS)) ? 11'(MAX_COLS) : 11'(cols_ff);
   assign base = AW'(r_ff) * AW'(MAX_COLS) + AW'(c_ff);
   assign csr_ready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata = {5'd0, op_ff, bad_ff, rd_ff};

   always_comb begin
      rd_addr = base;
      case (k_ff)
         3'd1: rd_addr = base - AW'(MAX_COLS);
         3'd2: rd_addr = base + AW'(MAX_COLS);
         3'd3: rd_addr = base - AW'(1);
         3'd4: rd_addr = base + AW'(1);
         default: rd_addr = base;
      endcase
   end

   hds_ram #(.WIDTH(TEMP_WIDTH), .DEPTH(DEPTH)) u_bank_a (
      .clock(clock), .wr_en(wr_a), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_a));
   hds_ram #(.WIDTH(TEMP_WIDTH), .DEPTH(DEPTH)) u_bank_b (
      .clock(clock), .wr_en(wr_b), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_b));
   assign rd_cur = bank_ff ? rd_b : rd_a;

   assign lr = DW'(n_ff) + DW'(s2_ff) - (DW'(t_ff) <<< 1);
   assign lc = DW'(w_ff) + DW'(e_ff) - (DW'(t_ff) <<< 1);
   assign mdiff = mk_ff[0] ? lc : lr;
   assign mcoef = mk_ff[0] ? (mk_ff[1] ? cc_ff[23:12] : cc_ff[11:0])
                           : (mk_ff[1] ? cr_ff[23:12] : cr_ff[11:0]);
   assign mhigh = mk_ff[1];
   assign mclear = (state_ff == S_CELL);
   assign macc = (state_ff == S_MAC);

   hds_alu #(.TEMP_WIDTH(TEMP_WIDTH)) u_alu (
      .clock(clock), .clear(mclear), .acc_en(macc), .diff(mdiff), .coef_half(mcoef),
      .high_half(mhigh), .hi_sum(hi_sum), .lo_sum(lo_sum));

   assign delta = (hi_sum + (lo_sum >>> 12)) >>> 12;
   assign sum = (SW+2)'(t_ff) + (SW+2)'(delta);
   assign newv = (sum > (SW+2)'(TMAX)) ? TMAX
               : (sum < (SW+2)'(TMIN)) ? TMIN : sum[TEMP_WIDTH-1:0];

   always_comb begin
      wr_a = 1'b0;
      wr_b = 1'b0;
      wr_addr = base;
      wr_data = edge_ff ? t_ff : newv;
      if (state_ff == S_MEM && op_ff == hds_pkg::OP_LOAD && !bad_ff) begin
         wr_data = val_ff;
         wr_a = !bank_ff;
         wr_b = bank_ff;
      end else if (state_ff == S_WRITE) begin
         wr_a = bank_ff;
         wr_b = !bank_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= 8'd100;
         cols_ff <= 8'd100;
         steps_ff <= 16'd1000;
         cr_ff <= 24'd1678;
         cc_ff <= 24'd1678;
         state_ff <= S_IDLE;
         bank_ff <= 1'b0;
         k_ff <= '0;
         mk_ff <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               hds_pkg::REG_ROWS: rows_ff <= csr_data[7:0];
               hds_pkg::REG_COLS: cols_ff <= csr_data[7:0];
               hds_pkg::REG_STEPS: steps_ff <= csr_data[15:0];
               hds_pkg::REG_COEF_ROW: cr_ff <= csr_data[23:0];
               hds_pkg::REG_COEF_COL: cc_ff <= csr_data[23:0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  op_ff <= in_op;
                  rd_ff <= '0;
                  k_ff <= '0;
                  r_ff <= RW'(in_row);
                  c_ff <= CW'(in_col);
                  val_ff <= in_temp;
                  bad_ff <= (in_op == hds_pkg::OP_LOAD || in_op == hds_pkg::OP_READ) &&
                            (11'(in_row) >= nr || 11'(in_col) >= nc);
                  if (in_op == hds_pkg::OP_RUN) begin
                     bad_ff <= 1'b0;
                     s_ff <= '0;
                     r_ff <= '0;
                     c_ff <= '0;
                     if (steps_ff == 16'd0 || nr == 11'd0 || nc == 11'd0) begin
                        // An empty grid still swaps the banks once per step.
                        bank_ff <= bank_ff ^ steps_ff[0];
                        state_ff <= S_RESP;
                     end else begin
                        state_ff <= S_CELL;
                     end
                  end else begin
                     state_ff <= S_MEM;
                  end
               end
            end
            S_MEM: state_ff <= S_MEMW;
            S_MEMW: begin
               if (op_ff == hds_pkg::OP_READ && !bad_ff) rd_ff <= 32'(rd_cur);
               state_ff <= S_RESP;
            end
            S_RESP: if (rsp_tready) state_ff <= S_IDLE;
            S_CELL: begin
               edge_ff <= (r_ff == '0) || (c_ff == '0) || (11'(r_ff) + 11'd1 == nr) ||
                          (11'(c_ff) + 11'd1 == nc);
               k_ff <= '0;
               state_ff <= S_FETCH;
            end
            S_FETCH: state_ff <= S_FWAIT;
            S_FWAIT: begin
               case (k_ff)
                  3'd0: t_ff <= rd_cur;
                  3'd1: n_ff <= rd_cur;
                  3'd2: s2_ff <= rd_cur;
                  3'd3: w_ff <= rd_cur;
                  default: e_ff <= rd_cur;
               endcase
               if (k_ff == 3'd4 || (k_ff == 3'd0 && edge_ff)) begin
                  mk_ff <= '0;
                  state_ff <= edge_ff ? S_WRITE : S_MAC;
               end else begin
                  k_ff <= k_ff + 3'd1;
                  state_ff <= S_FETCH;
               end
            end
            S_MAC: begin
               mk_ff <= mk_ff + 3'd1;
               if (mk_ff == 3'd3) state_ff <= S_WRITE;
            end
            S_WRITE: begin
               k_ff <= '0;
               state_ff <= S_NEXT;
            end
            default: begin
               state_ff <= S_CELL;
               if (11'(c_ff) + 11'd1 == nc) begin
                  c_ff <= '0;
                  if (11'(r_ff) + 11'd1 == nr) begin
                     r_ff <= '0;
                     bank_ff <= !bank_ff;
                     s_ff <= s_ff + 16'd1;
                     if (s_ff + 16'd1 == steps_ff) state_ff <= S_RESP;
                  end else begin
                     r_ff <= r_ff + RW'(1);
                  end
               end else begin
                  c_ff <= c_ff + CW'(1);
               end
            end
         endcase
      end
   end

   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request taken while response pending");
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[31:0] == 32'd0)
      else $error("out-of-grid answer carries data");
endmodule
